// ===== hdl/audio_fifo_prefill_underrun_hold_core_defines.svh =====
// Assertion macros shared by the audio FIFO core.
`ifndef AUDIO_FIFO_PREFILL_UNDERRUN_HOLD_CORE_DEFINES_SVH
`define AUDIO_FIFO_PREFILL_UNDERRUN_HOLD_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define AFPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define AFPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/afph_pkg.sv =====
// Shared types and constants for the audio FIFO core.
package afph_pkg;

  localparam int unsigned FifoDepthDefault = 32768;
  localparam int unsigned BlockMax         = 4096;
  localparam int unsigned PrefillReset     = 8192;
  localparam int unsigned BlockReset       = 2048;
  localparam int unsigned CfgW             = 15;
  localparam int unsigned BlockW           = 13;
  localparam int unsigned BlockPosW        = 12;

  localparam logic REG_PREFILL = 1'b0;
  localparam logic REG_BLOCK   = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [15:0] sample_in;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic signed [15:0] play_sample;
    logic               padded;
    logic               playing;
    logic [14:0]        fill_level;
    logic [14:0]        space_left;
  } out_t;

  // Control part of a result, waiting next to the read data of the store.
  typedef struct packed {
    logic        accepted;
    logic        pop;
    logic        played;
    logic        padded;
    logic        clr;
    logic        playing;
    logic [14:0] fill_level;
    logic [14:0] space_left;
  } res_t;

endpackage

// ===== hdl/audio_fifo_prefill_underrun_hold_core.sv =====
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls; pointer and block
// updates finish in the accept cycle; the store has one write and one read port.
// Reset clears pointers, fill, playback and block state and the held sample,
// and loads prefill 8192 and block length 2048; the store is not cleared.
`include "audio_fifo_prefill_underrun_hold_core_defines.svh"

module audio_fifo_prefill_underrun_hold_core
  import afph_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_t            out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);

  logic [CfgW-1:0]      prefill_q;
  logic [BlockW-1:0]    block_len_q;
  logic [PtrW-1:0]      wp_q, wp_d, rp_q, rp_d, fill_q, fill_d;
  logic                 play_q, play_d;
  logic [BlockPosW-1:0] bpos_q, bpos_d;
  logic [BlockW-1:0]    btake_q, btake_d;
  logic                 s1_vld_q;
  res_t                 s1_q, res_d;
  logic signed [15:0]   held_q;
  logic [15:0]          rdata;
  logic                 in_fire, out_fire;
  logic                 push, pop;
  logic [BlockW-1:0]    eff_len, take;
  logic [BlockW-1:0]    bpos_inc;
  logic [31:0]          ptr_diff;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = s1_vld_q && out_ready_i;
  assign in_ready_o = !s1_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefill_q   <= CfgW'(PrefillReset);
      block_len_q <= BlockW'(BlockReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PREFILL: prefill_q   <= cfg_data_i;
        REG_BLOCK:   block_len_q <= cfg_data_i[BlockW-1:0];
      endcase
    end
  end

  always_comb begin
    if (block_len_q == '0) begin
      eff_len = BlockW'(1);
    end else if (block_len_q > BlockW'(BlockMax)) begin
      eff_len = BlockW'(BlockMax);
    end else begin
      eff_len = block_len_q;
    end
  end

  // A new block fixes its take from the fill seen at its first slot.
  always_comb begin
    if (bpos_q != '0) begin
      take = btake_q;
    end else if (32'(fill_q) < 32'(eff_len)) begin
      take = BlockW'(fill_q);
    end else begin
      take = eff_len;
    end
  end

  assign bpos_inc = BlockW'(bpos_q) + BlockW'(1);
  assign push = (in_data_i.cmd == CMD_PUSH) && (fill_q != PtrLast);
  assign pop  = (in_data_i.cmd == CMD_PULL) && play_q &&
                (BlockW'(bpos_q) < take) && (fill_q != '0);

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    fill_d  = fill_q;
    play_d  = play_q;
    bpos_d  = bpos_q;
    btake_d = btake_q;
    res_d   = '0;
    unique case (in_data_i.cmd)
      CMD_PUSH: begin
        if (push) begin
          wp_d   = (wp_q == PtrLast) ? '0 : wp_q + PtrW'(1);
          fill_d = fill_q + PtrW'(1);
          res_d.accepted = 1'b1;
          if (!play_q && (32'(fill_q) + 32'd1 >= 32'(prefill_q))) begin
            play_d  = 1'b1;
            bpos_d  = '0;
            btake_d = '0;
          end
        end
      end
      CMD_PULL: begin
        if (play_q) begin
          btake_d      = take;
          res_d.played = 1'b1;
          res_d.pop    = pop;
          res_d.padded = !pop;
          if (pop) begin
            rp_d   = (rp_q == PtrLast) ? '0 : rp_q + PtrW'(1);
            fill_d = fill_q - PtrW'(1);
          end
          bpos_d = (bpos_inc >= eff_len) ? '0 : bpos_inc[BlockPosW-1:0];
        end
      end
      CMD_START: begin
        wp_d      = '0;
        rp_d      = '0;
        fill_d    = '0;
        play_d    = 1'b0;
        bpos_d    = '0;
        btake_d   = '0;
        res_d.clr = 1'b1;
      end
      CMD_STOP: begin
        play_d  = 1'b0;
        bpos_d  = '0;
        btake_d = '0;
      end
    endcase
    res_d.playing    = play_d;
    res_d.fill_level = 15'(fill_d);
    res_d.space_left = 15'(PtrLast - fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      fill_q  <= '0;
      play_q  <= 1'b0;
      bpos_q  <= '0;
      btake_q <= '0;
    end else if (in_fire) begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      fill_q  <= fill_d;
      play_q  <= play_d;
      bpos_q  <= bpos_d;
      btake_q <= btake_d;
    end
  end

  // A pop always reads an entry written in an earlier cycle, so the store
  // needs no forwarding path.
  afph_ram #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .AW        (PtrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (in_fire && push),
    .waddr_i(wp_q),
    .wdata_i(in_data_i.sample_in),
    .re_i   (in_fire && pop),
    .raddr_i(rp_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= res_d;
    end
  end

  // The held sample follows results as they leave, so it stays in item order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (out_fire) begin
      if (s1_q.clr) begin
        held_q <= '0;
      end else if (s1_q.pop) begin
        held_q <= rdata;
      end
    end
  end

  always_comb begin
    out_data_o.accepted = s1_q.accepted;
    if (s1_q.pop) begin
      out_data_o.play_sample = rdata;
    end else if (s1_q.played) begin
      out_data_o.play_sample = held_q;
    end else begin
      out_data_o.play_sample = '0;
    end
    out_data_o.padded     = s1_q.padded;
    out_data_o.playing    = s1_q.playing;
    out_data_o.fill_level = s1_q.fill_level;
    out_data_o.space_left = s1_q.space_left;
  end

  assign out_valid_o = s1_vld_q;

  assign ptr_diff = 32'(wp_q) - 32'(rp_q) + ((wp_q < rp_q) ? 32'(FIFO_DEPTH) : 32'd0);

  `AFPH_ASSERT(a_fill_bound, fill_q <= PtrLast, "fill exceeds capacity")
  `AFPH_ASSERT(a_fill_ptrs, ptr_diff == 32'(fill_q), "fill disagrees with pointers")
  `AFPH_ASSERT_IMP(a_pop_nonempty, in_fire && pop, fill_q != '0, "pop from empty store")
  `AFPH_ASSERT_IMP(a_block_idle, bpos_q != '0, play_q, "block open while stopped")
  `AFPH_ASSERT_IMP(a_pad_playing, s1_vld_q && s1_q.padded, s1_q.playing, "pad while stopped")

endmodule

// ===== hdl/afph_ram.sv =====
// Sample store: one write port, one read port with registered read data.
module afph_ram
  import afph_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDefault,
  parameter int unsigned AW         = $clog2(FIFO_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem_q [FIFO_DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while re_i is low, so a stalled result keeps its sample.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/audio_fifo_prefill_underrun_hold_core_tb.sv =====
// Self-checking testbench for the audio FIFO core with prefill and underrun hold.
module audio_fifo_prefill_underrun_hold_core_tb
  import afph_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth      = FifoDepthDefault;
  localparam int unsigned CycleLimit = 2000000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_t             in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_t            out_data;
  logic            cfg_we = 1'b0;
  logic            cfg_idx = REG_PREFILL;
  logic [CfgW-1:0] cfg_data = '0;

  in_t  cmd_backlog[$];
  out_t predicted_out[$];
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   fail_count = 0;
  int unsigned cycle_count = 0;

  // Shadow of the FIFO, playback and block state.
  logic signed [15:0] sample_mem [Depth];
  int unsigned        wr_ptr = 0;
  int unsigned        rd_ptr = 0;
  bit                 play_on = 1'b0;
  logic signed [15:0] held_sample = '0;
  int unsigned        blk_pos = 0;
  int unsigned        blk_take = 0;
  int unsigned        prefill_cfg = PrefillReset;
  int unsigned        block_cfg = BlockReset;

  audio_fifo_prefill_underrun_hold_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned fifo_fill();
    return (wr_ptr + Depth - rd_ptr) % Depth;
  endfunction

  function automatic out_t predict_fifo_step(in_t item);
    out_t        res;
    int unsigned len;
    int unsigned fill;
    res = '0;
    case (item.cmd)
      CMD_PUSH: begin
        if (fifo_fill() < Depth - 1) begin
          sample_mem[wr_ptr] = item.sample_in;
          wr_ptr = (wr_ptr + 1) % Depth;
          res.accepted = 1'b1;
          if (!play_on && fifo_fill() >= prefill_cfg) begin
            play_on = 1'b1;
            blk_pos = 0;
            blk_take = 0;
          end
        end
      end
      CMD_PULL: begin
        if (play_on) begin
          len = (block_cfg == 0) ? 1 : ((block_cfg > BlockMax) ? BlockMax : block_cfg);
          // The block's share of queued samples is fixed at its first slot.
          if (blk_pos == 0) begin
            fill = fifo_fill();
            blk_take = (fill < len) ? fill : len;
          end
          if (blk_pos < blk_take && fifo_fill() > 0) begin
            held_sample = sample_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % Depth;
          end else begin
            res.padded = 1'b1;
          end
          res.play_sample = held_sample;
          blk_pos++;
          if (blk_pos >= len) blk_pos = 0;
        end
      end
      CMD_START: begin
        wr_ptr = 0;
        rd_ptr = 0;
        play_on = 1'b0;
        held_sample = '0;
        blk_pos = 0;
        blk_take = 0;
      end
      default: begin
        play_on = 1'b0;
        blk_pos = 0;
        blk_take = 0;
      end
    endcase
    fill = fifo_fill();
    res.playing = play_on;
    res.fill_level = fill[14:0];
    res.space_left = 15'(Depth - 1 - fill);
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Sender: a new item goes out only once the previous one was taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= cmd_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predicted_out.push_back(predict_fifo_step(in_data));
      if (out_valid && out_ready) begin
        if (predicted_out.size() == 0) begin
          $error("result arrived with no item outstanding");
          fail_count++;
        end else begin
          want = predicted_out.pop_front();
          check_field("accepted", want.accepted, out_data.accepted);
          check_field("play_sample", want.play_sample, out_data.play_sample);
          check_field("padded", want.padded, out_data.padded);
          check_field("playing", want.playing, out_data.playing);
          check_field("fill_level", want.fill_level, out_data.fill_level);
          check_field("space_left", want.space_left, out_data.space_left);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("audio_fifo_prefill_underrun_hold_core verification failed");
      $finish;
    end
  end

  task automatic queue_cmd(cmd_e cmd, logic signed [15:0] sample);
    in_t item;
    item.cmd = cmd;
    item.sample_in = sample;
    cmd_backlog.push_back(item);
  endtask

  task automatic write_reg(logic idx, logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PREFILL) prefill_cfg = value;
    else block_cfg = value[BlockW-1:0];
  endtask

  // Holds off until every queued item is sent and every result is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || predicted_out.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      1: begin
        send_idle_pct = 66;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 66;
      end
      3: begin
        send_idle_pct = 25;
        stall_pct = 25;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  task automatic queue_random(int count, int push_pct);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) queue_cmd(CMD_START, 16'($urandom()));
      else if (pick < 6) queue_cmd(CMD_STOP, 16'($urandom()));
      else if (pick < 6 + push_pct * 94 / 100) queue_cmd(CMD_PUSH, 16'($urandom()));
      else queue_cmd(CMD_PULL, 16'($urandom()));
    end
  endtask

  initial begin
    int pf;
    int bl;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset settings: pull while stopped, sample extremes, stop and start.
    queue_cmd(CMD_PULL, 16'sh1234);
    queue_cmd(CMD_PUSH, 16'sh8000);
    queue_cmd(CMD_PUSH, 16'sh7FFF);
    queue_cmd(CMD_STOP, 16'sh0000);
    queue_cmd(CMD_PULL, 16'sh0000);
    queue_cmd(CMD_START, 16'sh0000);
    queue_cmd(CMD_PULL, 16'sh0000);
    wait_drained();

    // Zero prefill starts on the first push; zero block length acts as one.
    write_reg(REG_PREFILL, 15'd0);
    write_reg(REG_BLOCK, 15'd0);
    queue_cmd(CMD_PUSH, 16'sh5555);
    queue_cmd(CMD_PULL, 16'sh0000);
    queue_cmd(CMD_PULL, 16'sh0000);
    queue_cmd(CMD_PUSH, 16'shAAAA);
    queue_cmd(CMD_STOP, 16'sh0000);
    queue_cmd(CMD_PULL, 16'sh0000);
    queue_cmd(CMD_PUSH, 16'sh0001);
    queue_cmd(CMD_PULL, 16'sh0000);
    queue_cmd(CMD_START, 16'sh0000);
    wait_drained();

    // Oversized block length is clamped; the block keeps its take after a late push.
    write_reg(REG_PREFILL, 15'd3);
    write_reg(REG_BLOCK, 15'h7FFF);
    queue_cmd(CMD_PUSH, 16'sh0000);
    queue_cmd(CMD_PUSH, 16'shFFFF);
    queue_cmd(CMD_PUSH, 16'sh0064);
    repeat (4) queue_cmd(CMD_PULL, 16'sh0000);
    queue_cmd(CMD_PUSH, 16'sh0007);
    queue_cmd(CMD_PULL, 16'sh0000);
    wait_drained();

    // Shrinking the block length mid-block ends the block at the new length.
    write_reg(REG_BLOCK, 15'd2);
    repeat (3) queue_cmd(CMD_PULL, 16'sh0000);
    queue_cmd(CMD_START, 16'sh0000);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        5: begin
          pf = 0;
          bl = 4097;
        end
        6: begin
          pf = 32767;
          bl = 15'h6005;
        end
        7: begin
          pf = 1;
          bl = 4096;
        end
        default: begin
          pf = $urandom_range(0, 24);
          bl = $urandom_range(0, 12);
        end
      endcase
      write_reg(REG_PREFILL, 15'(pf));
      write_reg(REG_BLOCK, 15'(bl));
      set_idling(ph % 4);
      queue_random(85, 40 + 15 * (ph % 3));
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("audio_fifo_prefill_underrun_hold_core verification clean");
    end else begin
      $display("audio_fifo_prefill_underrun_hold_core verification failed");
    end
    $finish;
  end

endmodule

// ===== audio_fifo_prefill_underrun_hold_core.f =====
+incdir+hdl
hdl/afph_pkg.sv
hdl/afph_ram.sv
hdl/audio_fifo_prefill_underrun_hold_core.sv
tb/sv/audio_fifo_prefill_underrun_hold_core_tb.sv
